>>> sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character map of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // depth of the group queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // character codes with a meaning of their own
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PAD   = 8'h3D;

  // sextet values of the two symbol characters
  localparam logic [5:0] SX_PLUS  = 6'd62;
  localparam logic [5:0] SX_SLASH = 6'd63;

  // one decoded group: bytes packed in emission order, index of the final one
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
  } grp_rec_t;

  // character to {valid, sextet}; pad and unknown codes map to zero
  function automatic logic [6:0] map_char(input logic [7:0] ch);
    logic [7:0] off;
    logic [6:0] res;
    off = 8'h00;
    res = 7'h00;
    case (ch) inside
      [8'h41:8'h5A]: begin
        off = ch - 8'h41;
        res = {1'b1, off[5:0]};
      end
      [8'h61:8'h7A]: begin
        off = ch - 8'h61 + 8'd26;
        res = {1'b1, off[5:0]};
      end
      [8'h30:8'h39]: begin
        off = ch - 8'h30 + 8'd52;
        res = {1'b1, off[5:0]};
      end
      CH_PLUS:  res = {1'b1, SX_PLUS};
      CH_SLASH: res = {1'b1, SX_SLASH};
      CH_PAD:   res = 7'h00;
      default:  res = 7'h00;
    endcase
    return res;
  endfunction

endpackage

>>> sv/b64d_if.sv
// ----------------------------------------------------------------------------
// b64d_if
// Valid/ready channels of the decoder: characters in, bytes out.
// ----------------------------------------------------------------------------
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_group;

  modport source (output valid, output data_byte, output last_of_group, input ready);
  modport sink (input valid, input data_byte, input last_of_group, output ready);
endinterface

>>> sv/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, gathers groups of four and pushes decoded groups.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                clk,
  input  logic                rst,
  b64d_char_if.sink           text,
  input  logic                q_full,
  output logic                push,
  output b64d_pkg::grp_rec_t  push_rec
);
  import b64d_pkg::*;

  logic [1:0]      group_position;
  logic [2:0][5:0] held_sextets;
  logic [2:0]      held_valid;
  logic            halted;

  logic [6:0] mapped;
  logic [5:0] sext;
  logic       cvalid;
  logic       accept;
  logic       complete;
  logic       good_head;
  logic [5:0] sx_c;
  logic [5:0] sx_d;

  assign text.ready = !q_full;
  assign accept     = text.valid && text.ready;

  // classify the incoming character
  assign mapped = map_char(text.char_code);
  assign sext   = mapped[5:0];
  assign cvalid = mapped[6];

  // group decode on the fourth character
  assign complete  = (group_position == 2'd3);
  assign good_head = held_valid[0] && held_valid[1];
  assign sx_c      = held_valid[2] ? held_sextets[2] : 6'd0;
  assign sx_d      = cvalid ? sext : 6'd0;

  always_comb begin
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = {held_sextets[0], held_sextets[1][5:4]};
    b1 = {held_sextets[1][3:0], sx_c[5:2]};
    b2 = {sx_c[1:0], sx_d};
    push_rec.bytes[0]  = b0;
    push_rec.bytes[1]  = held_valid[2] ? b1 : b2;
    push_rec.bytes[2]  = b2;
    push_rec.last_idx  = 2'({1'b0, held_valid[2]} + {1'b0, cvalid});
  end

  assign push = accept && complete && good_head && !halted;

  // group position, held characters and halt flag
  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 2'd0;
      held_valid     <= 3'b000;
      halted         <= 1'b0;
    end else if (accept) begin
      if (!complete) begin
        held_sextets[group_position] <= sext;
        held_valid[group_position]   <= cvalid;
        group_position               <= group_position + 2'd1;
      end else begin
        group_position <= 2'd0;
        held_valid     <= 3'b000;
        if (!good_head) begin
          halted <= 1'b1;
        end
      end
      // end of text drops a partial group and lifts the halt
      if (text.end_of_text) begin
        group_position <= 2'd0;
        held_valid     <= 3'b000;
        halted         <= 1'b0;
      end
    end
  end

endmodule

>>> sv/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short queue of decoded groups between front and back.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64d_pkg::grp_rec_t  push_rec,
  input  logic                pop,
  output b64d_pkg::grp_rec_t  head_rec,
  output logic                full,
  output logic                empty
);
  import b64d_pkg::*;

  grp_rec_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W + 1)'(QDEPTH));
  assign empty    = (count == '0);
  assign head_rec = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Takes groups from the queue and sends their bytes one item per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                clk,
  input  logic                rst,
  input  b64d_pkg::grp_rec_t  head_rec,
  input  logic                q_empty,
  output logic                pop,
  b64d_byte_if.source         data
);
  import b64d_pkg::*;

  grp_rec_t   cur;
  logic       cur_valid;
  logic [1:0] idx;

  logic load_out;
  logic at_last;
  logic finishing;
  logic fetch;

  assign load_out  = !data.valid || data.ready;
  assign at_last   = (idx == cur.last_idx);
  assign finishing = cur_valid && load_out && at_last;
  assign fetch     = (!cur_valid || finishing) && !q_empty;
  assign pop       = fetch;

  // current group and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      data.valid <= 1'b0;
      cur_valid  <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (load_out) begin
        data.valid <= cur_valid;
        if (cur_valid) begin
          data.data_byte     <= cur.bytes[idx];
          data.last_of_group <= at_last;
          idx                <= idx + 2'd1;
        end
      end
      if (fetch) begin
        cur       <= head_rec;
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (finishing) begin
        cur_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, one character in per item, one byte out per item.
// ----------------------------------------------------------------------------
// The decoder takes one character every cycle while the queue is not full
// and sends at most one byte every cycle; a group of four characters yields
// one to three bytes, the last flagged with last_of_group, so the input
// never has to wait on a free-running sink. A byte passes the queue, the
// current group register and the output register after the fourth
// character of its group. A four-entry group queue sets how far output
// stalls can be absorbed before the character input deasserts ready. A
// group whose first or second character is not in the alphabet stops output
// up to the end of the text; end_of_text drops a trailing partial group.
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  b64d_char_if.sink   text,
  b64d_byte_if.source data
);
  import b64d_pkg::*;

  grp_rec_t push_rec;
  grp_rec_t head_rec;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;

  // character intake and group decode
  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .text     (text),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  // decoded group queue
  b64d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  // byte output
  b64d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_rec (head_rec),
    .q_empty  (q_empty),
    .pop      (pop),
    .data     (data)
  );

endmodule

>>> sv/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the decoder, attached to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic       clk,
  input logic       rst,
  input logic       text_ready,
  input logic       data_valid,
  input logic       data_ready,
  input logic [7:0] data_byte,
  input logic       data_last
);

  // a stalled item holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    data_valid && !data_ready |=> data_valid && $stable(data_byte) && $stable(data_last))
    else $error("stalled output item changed");

  // no output item right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !data_valid)
    else $error("output item valid after reset");

  // queue is empty after reset so characters are taken
  a_reset_ready: assert property (@(posedge clk)
    rst |=> text_ready)
    else $error("input not ready after reset");

  // bytes of one group follow each other without a gap
  a_group_burst: assert property (@(posedge clk) disable iff (rst)
    data_valid && data_ready && !data_last |=> data_valid)
    else $error("gap inside a group");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst        (rst),
  .text_ready (text.ready),
  .data_valid (data.valid),
  .data_ready (data.ready),
  .data_byte  (data.data_byte),
  .data_last  (data.last_of_group)
);
